@@ sv/assert_macros.svh @@
// Assertion helpers shared by the RTL. Both expect clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off during reset
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, held off during reset
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ sv/wmv_pkg.sv @@
`timescale 1ns / 1ps
package wmv_pkg;

  // Fixed field widths
  localparam int RATE_BITS  = 16;
  localparam int ROW_W      = 13;  // row counter, counts the two drain rows
  localparam int OUT_ROW_W  = 12;
  localparam int OUT_COL_W  = 10;
  localparam int MEAN_W     = 15;
  localparam int RESID_W    = 17;
  localparam int VAR_W      = 48;
  localparam int NROWS_W    = 12;
  localparam int NCOLS_W    = 11;
  localparam int SCALE_W    = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Accumulator and shared unit widths
  localparam int N_W       = 5;   // up to 25 cells
  localparam int NN_W      = 4;   // up to 9 cells
  localparam int SUM_W     = 20;
  localparam int SQ_W      = 35;
  localparam int NUM_W     = 40;
  localparam int MUL_A_W   = 40;
  localparam int MUL_B_W   = 20;
  localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
  localparam int DVD_W     = 48;
  localparam int DVS_W     = 10;
  localparam int DIV_CNT_W = 6;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_ROWS    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_COLS    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ERROR_SCALE = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD,
    S_CLR,
    S_CELL,
    S_ACC,
    S_D5,
    S_D3,
    S_V1,
    S_V2,
    S_V3,
    S_V4,
    S_V5,
    S_DIV,
    S_PUSH
  } state_t;

endpackage

@@ sv/wmv_ram.sv @@
`timescale 1ns / 1ps
module wmv_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ sv/window_mean_variance_5x5_3x3_unit.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"
// Clipped 5x5 / 3x3 window statistics over a raster streamed in row-major order.
// Input channel: in_rate/in_func with in_valid/in_stall. Pixel items carry a rate
// (negative marks a missing cell); after the last pixel, two rows of drain items
// flush the final two rows. Items of the wrong kind are dropped without results.
// Output channel: one result per grid cell with out_valid/out_stall; a result
// trails its cell by two rows and two columns, and the last cell of a row
// releases up to three results. out_last_of_run marks the last result of an item.
// Each result walks the 25 window cells, then runs three 48-step divisions on
// one shared bit-serial divider and four products on one shared multiplier,
// which also squares each cell. in_stall is high from acceptance of an item of
// the right kind until its last result, if any, sits in the output register;
// that register frees the datapath while the receiver holds out_stall, and the
// sequencer waits there only when a second result is ready.
// The line store (MAX_COLS words of four rows) needs no clearing pass.
// Reset (rst_n low, synchronous) returns to frame position (0,0), clears the
// window and loads 64 rows, 64 columns and a scale of 1.0.
module window_mean_variance_5x5_3x3_unit #(
  parameter int MAX_COLS = 1024
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     in_valid,
  output logic                                     in_stall,
  input  logic signed [wmv_pkg::RATE_BITS-1:0]     in_rate,
  input  logic                                     in_func,
  output logic                                     out_valid,
  input  logic                                     out_stall,
  output logic [wmv_pkg::OUT_ROW_W-1:0]            out_center_row,
  output logic [wmv_pkg::OUT_COL_W-1:0]            out_center_col,
  output logic [wmv_pkg::MEAN_W-1:0]               out_mean_5x5,
  output logic [wmv_pkg::MEAN_W-1:0]               out_mean_3x3,
  output logic signed [wmv_pkg::RESID_W-1:0]       out_residual,
  output logic [wmv_pkg::VAR_W-1:0]                out_error_variance,
  output logic                                     out_variance_valid,
  output logic                                     out_frame_done,
  output logic                                     out_last_of_run,
  input  logic                                     cfg_we,
  input  logic [wmv_pkg::CFG_IDX_W-1:0]            cfg_index,
  input  logic [wmv_pkg::CFG_DATA_W-1:0]           cfg_wdata
);
  import wmv_pkg::*;

  localparam int CW   = $clog2(MAX_COLS);
  localparam int CCW  = $clog2(MAX_COLS + 1);
  localparam int CQW  = CCW + 2;
  localparam int WORD = 4 * RATE_BITS;

  // Configuration
  logic [NROWS_W-1:0] num_rows_r;
  logic [NCOLS_W-1:0] grid_cols_r;
  logic [SCALE_W-1:0] error_scale_r;
  logic [NROWS_W-1:0] r_eff;
  logic [CCW-1:0]     c_eff;

  // Control
  state_t         state_r, state_nxt, ret_r;
  logic [ROW_W-1:0] row_r, row_nxt, v_cur, adv_row;
  logic [CW-1:0]  col_r, col_nxt, c_cur, adv_col;
  logic           out_valid_r, out_valid_nxt;
  logic           in_accept, wrap, kind_bad, push, out_free;
  logic           last_col, emit_any, acc_last, div_done;
  logic [1:0]     k_start;
  logic [CQW-1:0] col_inc;
  logic [ROW_W-1:0] row_inc;

  // Window and line store
  logic signed [RATE_BITS-1:0] win_r [5][5];
  logic signed [RATE_BITS-1:0] rd_slot [4];
  logic signed [RATE_BITS-1:0] rate_r;
  logic [WORD-1:0] ram_rdata, ram_wdata;
  logic            ram_we;

  // Cell walk
  logic [2:0]     p_r, q_r, wc, wc_idx;
  logic [1:0]     k_r, klast_r;
  logic [ROW_W:0] vp;
  logic [CQW-1:0] cq, cc;
  logic           row_ok, col_ok, cell_in, cell_inner;
  logic signed [RATE_BITS-1:0] cell_val, cval_r, centre_r;
  logic           cin_r, cinner_r;

  // Accumulators and results
  logic [N_W-1:0]   n_r;
  logic [NN_W-1:0]  nn_r;
  logic [SUM_W-1:0] sum_r, sum3_r;
  logic [SQ_W-1:0]  sum2_r;
  logic [NUM_W-1:0] t1_r, num_r;
  logic [DVS_W-1:0] m_r;
  logic [MEAN_W-1:0] mean5_r, mean3_r;

  // Shared multiplier
  logic [MUL_A_W-1:0] mul_a_r;
  logic [MUL_B_W-1:0] mul_b_r;
  logic [MUL_P_W-1:0] mul_p;

  // Shared bit-serial divider
  logic [DVD_W-1:0]     div_q_r;
  logic [DVS_W-1:0]     div_d_r, div_rem_r;
  logic [DIV_CNT_W-1:0] div_cnt_r;
  logic [DVS_W:0]       div_rs;
  logic                 div_ge;

  // Output register payload
  logic [OUT_ROW_W-1:0]      out_row_r;
  logic [OUT_COL_W-1:0]      out_col_r;
  logic [MEAN_W-1:0]         out_m5_r, out_m3_r;
  logic signed [RESID_W-1:0] out_res_r;
  logic [VAR_W-1:0]          out_var_r;
  logic                      out_vv_r, out_frame_done_r, out_last_r;

  // Effective grid size
  always_comb begin
    r_eff = (num_rows_r == '0) ? NROWS_W'(1) : num_rows_r;
    if (grid_cols_r == '0) begin
      c_eff = CCW'(1);
    end else if (32'(grid_cols_r) > 32'(MAX_COLS)) begin
      c_eff = CCW'(MAX_COLS);
    end else begin
      c_eff = CCW'(grid_cols_r);
    end
  end

  // Position checks on acceptance
  assign in_stall  = (state_r != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign wrap      = (CQW'(col_r) >= CQW'(c_eff)) ||
                     (row_r >= (ROW_W'(r_eff) + ROW_W'(2)));
  assign v_cur     = wrap ? '0 : row_r;
  assign c_cur     = wrap ? '0 : col_r;
  assign kind_bad  = in_func != (v_cur >= ROW_W'(r_eff));

  // Position advance and emission range
  always_comb begin
    col_inc = CQW'(col_r) + CQW'(1);
    row_inc = row_r + ROW_W'(1);
    if (col_inc >= CQW'(c_eff)) begin
      adv_col = '0;
      adv_row = (row_inc >= (ROW_W'(r_eff) + ROW_W'(2))) ? '0 : row_inc;
    end else begin
      adv_col = CW'(col_inc);
      adv_row = row_r;
    end
    last_col = CQW'(col_r) == (CQW'(c_eff) - CQW'(1));
    emit_any = (row_r >= ROW_W'(2)) && (last_col || (CQW'(col_r) >= CQW'(2)));
    if (!last_col || CQW'(col_r) >= CQW'(2)) begin
      k_start = 2'd0;
    end else if (col_r == CW'(1)) begin
      k_start = 2'd1;
    end else begin
      k_start = 2'd2;
    end
  end

  // Line store: one word holds the four previous rows of a column
  always_comb begin
    for (int dr = 0; dr < 4; dr++) begin
      rd_slot[dr] = ram_rdata[int'(2'(row_r[1:0] + 2'(dr))) * RATE_BITS +: RATE_BITS];
    end
    ram_wdata = ram_rdata;
    ram_wdata[int'(row_r[1:0]) * RATE_BITS +: RATE_BITS] = rate_r;
  end

  assign ram_we = (state_r == S_RD);

  wmv_ram #(
    .WIDTH(WORD),
    .DEPTH(MAX_COLS)
  ) u_line_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(col_r),
    .wdata(ram_wdata),
    .raddr(c_cur),
    .rdata(ram_rdata)
  );

  // Cell selection for the walk over the window
  always_comb begin
    wc         = q_r + 3'(k_r);
    wc_idx     = (wc > 3'd4) ? 3'd4 : wc;
    vp         = (ROW_W+1)'(row_r) + (ROW_W+1)'(p_r);
    row_ok     = (vp >= (ROW_W+1)'(4)) && (vp < ((ROW_W+1)'(r_eff) + (ROW_W+1)'(4)));
    cq         = CQW'(col_r) + CQW'(k_r) + CQW'(q_r);
    col_ok     = (cq >= CQW'(4)) && (cq < (CQW'(c_eff) + CQW'(4)));
    cell_in    = (wc <= 3'd4) && row_ok && col_ok;
    cell_inner = (p_r >= 3'd1) && (p_r <= 3'd3) && (q_r >= 3'd1) && (q_r <= 3'd3);
    cell_val   = win_r[p_r][wc_idx];
    acc_last   = (p_r == 3'd4) && (q_r == 3'd4);
    cc         = CQW'(col_r) + CQW'(k_r) - CQW'(2);
  end

  // Shared units
  assign mul_p    = MUL_P_W'(mul_a_r) * MUL_P_W'(mul_b_r);
  assign div_rs   = {div_rem_r, div_q_r[DVD_W-1]};
  assign div_ge   = div_rs >= {1'b0, div_d_r};
  assign div_done = div_cnt_r == DIV_CNT_W'(DVD_W - 1);
  assign out_free = !out_valid_r || !out_stall;

  // Sequencer: next state and strobes
  always_comb begin
    state_nxt = state_r;
    row_nxt   = row_r;
    col_nxt   = col_r;
    push      = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          row_nxt = v_cur;
          col_nxt = c_cur;
          if (!kind_bad) begin
            state_nxt = S_RD;
          end
        end
      end
      S_RD: begin
        if (emit_any) begin
          state_nxt = S_CLR;
        end else begin
          row_nxt   = adv_row;
          col_nxt   = adv_col;
          state_nxt = S_IDLE;
        end
      end
      S_CLR:  state_nxt = S_CELL;
      S_CELL: state_nxt = S_ACC;
      S_ACC:  state_nxt = acc_last ? S_D5 : S_CELL;
      S_D5:   state_nxt = S_DIV;
      S_D3:   state_nxt = S_DIV;
      S_V1:   state_nxt = S_V2;
      S_V2:   state_nxt = S_V3;
      S_V3:   state_nxt = S_V4;
      S_V4:   state_nxt = S_V5;
      S_V5:   state_nxt = S_DIV;
      S_DIV:  state_nxt = div_done ? ret_r : S_DIV;
      S_PUSH: begin
        if (out_free) begin
          push = 1'b1;
          if (k_r == klast_r) begin
            row_nxt   = adv_row;
            col_nxt   = adv_col;
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_CLR;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    if (push) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // Control registers and configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      row_r         <= '0;
      col_r         <= '0;
      out_valid_r   <= 1'b0;
      num_rows_r    <= NROWS_W'(64);
      grid_cols_r   <= NCOLS_W'(64);
      error_scale_r <= SCALE_W'(256);
    end else begin
      state_r     <= state_nxt;
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_NUM_ROWS:    num_rows_r    <= cfg_wdata[NROWS_W-1:0];
          CFG_NUM_COLS:    grid_cols_r   <= cfg_wdata[NCOLS_W-1:0];
          CFG_ERROR_SCALE: error_scale_r <= cfg_wdata[SCALE_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Window: shift left, new column from the line store and the incoming rate
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < 5; r++) begin
        for (int k = 0; k < 5; k++) begin
          win_r[r][k] <= '0;
        end
      end
    end else if (state_r == S_RD) begin
      for (int r = 0; r < 5; r++) begin
        for (int k = 0; k < 4; k++) begin
          win_r[r][k] <= win_r[r][k+1];
        end
      end
      for (int r = 0; r < 4; r++) begin
        win_r[r][4] <= rd_slot[r];
      end
      win_r[4][4] <= rate_r;
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          rate_r <= in_func ? '0 : in_rate;
        end
      end
      S_RD: begin
        k_r     <= k_start;
        klast_r <= last_col ? 2'd2 : 2'd0;
      end
      S_CLR: begin
        n_r    <= '0;
        nn_r   <= '0;
        sum_r  <= '0;
        sum3_r <= '0;
        sum2_r <= '0;
        p_r    <= '0;
        q_r    <= '0;
      end
      S_CELL: begin
        cin_r    <= cell_in;
        cinner_r <= cell_inner;
        cval_r   <= cell_val;
        if (p_r == 3'd2 && q_r == 3'd2) begin
          centre_r <= cell_val;
        end
        mul_a_r <= (cell_in && !cell_val[RATE_BITS-1]) ? MUL_A_W'(unsigned'(cell_val)) : '0;
        mul_b_r <= (cell_in && !cell_val[RATE_BITS-1]) ? MUL_B_W'(unsigned'(cell_val)) : '0;
      end
      S_ACC: begin
        if (cin_r) begin
          n_r <= n_r + N_W'(1);
          if (cinner_r) begin
            nn_r <= nn_r + NN_W'(1);
          end
          if (!cval_r[RATE_BITS-1]) begin
            sum_r  <= sum_r + SUM_W'(unsigned'(cval_r));
            sum2_r <= sum2_r + mul_p[SQ_W-1:0];
            if (cinner_r) begin
              sum3_r <= sum3_r + SUM_W'(unsigned'(cval_r));
            end
          end
        end
        if (q_r == 3'd4) begin
          q_r <= '0;
          p_r <= p_r + 3'd1;
        end else begin
          q_r <= q_r + 3'd1;
        end
      end
      S_D5: begin
        div_q_r   <= DVD_W'(sum_r);
        div_d_r   <= DVS_W'(n_r);
        div_rem_r <= '0;
        div_cnt_r <= '0;
        ret_r     <= S_D3;
      end
      S_D3: begin
        mean5_r   <= div_q_r[MEAN_W-1:0];
        div_q_r   <= DVD_W'(sum3_r);
        div_d_r   <= DVS_W'(nn_r);
        div_rem_r <= '0;
        div_cnt_r <= '0;
        ret_r     <= S_V1;
      end
      S_V1: begin
        mean3_r <= div_q_r[MEAN_W-1:0];
        mul_a_r <= MUL_A_W'(sum2_r);
        mul_b_r <= MUL_B_W'(n_r);
      end
      S_V2: begin
        t1_r    <= mul_p[NUM_W-1:0];
        mul_a_r <= MUL_A_W'(sum_r);
        mul_b_r <= MUL_B_W'(sum_r);
      end
      S_V3: begin
        num_r   <= t1_r - mul_p[NUM_W-1:0];
        mul_a_r <= MUL_A_W'(n_r);
        mul_b_r <= MUL_B_W'(n_r - N_W'(1));
      end
      S_V4: begin
        m_r     <= mul_p[DVS_W-1:0];
        mul_a_r <= MUL_A_W'(num_r);
        mul_b_r <= MUL_B_W'(error_scale_r);
      end
      S_V5: begin
        // divide by 256 first, then by n*(n-1)
        div_q_r   <= mul_p[DVD_W+7:8];
        div_d_r   <= m_r;
        div_rem_r <= '0;
        div_cnt_r <= '0;
        ret_r     <= S_PUSH;
      end
      S_DIV: begin
        div_rem_r <= div_ge ? DVS_W'(div_rs - {1'b0, div_d_r}) : div_rs[DVS_W-1:0];
        div_q_r   <= {div_q_r[DVD_W-2:0], div_ge};
        div_cnt_r <= div_cnt_r + DIV_CNT_W'(1);
      end
      S_PUSH: begin
        if (push) begin
          out_row_r        <= OUT_ROW_W'(row_r - ROW_W'(2));
          out_col_r        <= OUT_COL_W'(cc);
          out_m5_r         <= mean5_r;
          out_m3_r         <= mean3_r;
          out_res_r        <= {centre_r[RATE_BITS-1], centre_r} - {2'b00, mean5_r};
          out_var_r        <= (n_r > N_W'(1)) ? div_q_r : '0;
          out_vv_r         <= n_r > N_W'(1);
          out_frame_done_r <= (row_r == (ROW_W'(r_eff) + ROW_W'(1))) &&
                              (cc == (CQW'(c_eff) - CQW'(1)));
          out_last_r       <= k_r == klast_r;
          if (k_r != klast_r) begin
            k_r <= k_r + 2'd1;
          end
        end
      end
      default: ;
    endcase
  end

  // Output ports
  assign out_valid          = out_valid_r;
  assign out_center_row     = out_row_r;
  assign out_center_col     = out_col_r;
  assign out_mean_5x5       = out_m5_r;
  assign out_mean_3x3       = out_m3_r;
  assign out_residual       = out_res_r;
  assign out_error_variance = out_var_r;
  assign out_variance_valid = out_vv_r;
  assign out_frame_done     = out_frame_done_r;
  assign out_last_of_run    = out_last_r;

  // Checks
  `ASSERT_IMPLIES(a_frame_end_last, out_valid_r && out_frame_done_r, out_last_r, "frame end not last of run")
  `ASSERT_IMPLIES(a_mean_count, state_r == S_D5, n_r != '0, "empty 5x5 window at division")
  `ASSERT_IMPLIES(a_inner_count, state_r == S_PUSH, N_W'(nn_r) <= n_r, "3x3 count above 5x5 count")
  `ASSERT_NEXT(a_push_valid, state_r == S_PUSH && out_free, out_valid_r, "result transfer lost")

endmodule
